>>> design/tftp_pkg.sv
package tftp_pkg;

	// TFTP opcodes as they arrive on the wire
	localparam logic [15:0] OPC_RRQ   = 16'd1;
	localparam logic [15:0] OPC_WRQ   = 16'd2;
	localparam logic [15:0] OPC_DATA  = 16'd3;
	localparam logic [15:0] OPC_ACK   = 16'd4;
	localparam logic [15:0] OPC_ERROR = 16'd5;

	// TFTP error codes
	localparam logic [2:0] ERR_NONE        = 3'd0;
	localparam logic [2:0] ERR_NOT_FOUND   = 3'd1;
	localparam logic [2:0] ERR_ILLEGAL     = 3'd4;
	localparam logic [2:0] ERR_UNKNOWN_TID = 3'd5;
	localparam logic [2:0] ERR_EXISTS      = 3'd6;

	localparam logic [3:0] MAX_TIMEOUTS_RST = 4'd5;
	localparam logic [3:0] TIMEOUT_SAT     = 4'd15;

	typedef enum logic [2:0] {
		CLS_RRQ,
		CLS_WRQ,
		CLS_DATA,
		CLS_ACK,
		CLS_ERROR,
		CLS_ILLEGAL
	} op_class_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_DATA = 2'd1,
		KIND_ACK  = 2'd2,
		KIND_ERR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_READ  = 2'd1,
		PH_WRITE = 2'd2
	} phase_t;

	// One classified event as it travels from the front to the back
	typedef struct packed {
		logic        tick;
		op_class_t   op;
		logic [15:0] block_num;
		logic [9:0]  payload_len;
		logic [31:0] src_addr;
		logic [15:0] src_port;
		logic        file_ok;
		logic [31:0] file_bytes;
	} entry_t;

	// One result word
	typedef struct packed {
		kind_t       kind;
		logic [15:0] blk;
		logic [9:0]  len;
		logic        retx;
		logic [2:0]  err;
		logic        to_sender;
		logic        store;
		logic        close;
		logic        discard;
		logic        ok;
	} result_t;

	localparam int unsigned QUEUE_DEPTH = 2;

endpackage

>>> design/tftp_front.sv
module tftp_front (
	input  logic              evt_valid,
	output logic              evt_ready,
	input  logic              req_type,
	input  logic [15:0]       opcode,
	input  logic [15:0]       block_num,
	input  logic [9:0]        payload_len,
	input  logic [31:0]       src_addr,
	input  logic [15:0]       src_port,
	input  logic              file_ok,
	input  logic [31:0]       file_bytes,
	input  logic              q_full,
	output logic              q_push,
	output tftp_pkg::entry_t  q_entry
);
	import tftp_pkg::*;

	op_class_t op_cls;

	// decode the opcode into a compact class
	always_comb begin
		unique case (opcode)
			OPC_RRQ:   op_cls = CLS_RRQ;
			OPC_WRQ:   op_cls = CLS_WRQ;
			OPC_DATA:  op_cls = CLS_DATA;
			OPC_ACK:   op_cls = CLS_ACK;
			OPC_ERROR: op_cls = CLS_ERROR;
			default:   op_cls = CLS_ILLEGAL;
		endcase
	end

	assign evt_ready = !q_full;
	assign q_push    = evt_valid && !q_full;

	always_comb begin
		q_entry.tick        = req_type;
		q_entry.op          = op_cls;
		q_entry.block_num   = block_num;
		q_entry.payload_len = payload_len;
		q_entry.src_addr    = src_addr;
		q_entry.src_port    = src_port;
		q_entry.file_ok     = file_ok;
		q_entry.file_bytes  = file_bytes;
	end

endmodule

>>> design/tftp_queue.sv
module tftp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tftp_pkg::entry_t  push_entry,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output tftp_pkg::entry_t  head
);
	import tftp_pkg::*;

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	entry_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full       = (count_q == CW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/tftp_back.sv
module tftp_back #(
	parameter int unsigned BLOCK_BYTES = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  tftp_pkg::entry_t   head,
	output logic               pop,
	input  logic [3:0]         max_timeouts,
	output logic               res_valid,
	input  logic               res_ready,
	output tftp_pkg::result_t  res
);
	import tftp_pkg::*;

	localparam logic [31:0] BLK32 = 32'(BLOCK_BYTES);
	localparam logic [10:0] BLK11 = 11'(BLOCK_BYTES);

	phase_t      phase_q, phase_d;
	logic [31:0] client_ip_q, client_ip_d;
	logic [15:0] client_port_q, client_port_d;
	logic [15:0] last_block_q, last_block_d;
	logic [31:0] bytes_left_q, bytes_left_d;
	logic [9:0]  last_len_q, last_len_d;
	logic        eof_q, eof_d;
	logic [3:0]  tcount_q, tcount_d;
	logic        res_valid_q;
	result_t     res_q, res_d;

	logic        in_read;
	logic        match;
	logic [31:0] sn_bytes;
	logic [15:0] sn_base;
	logic [15:0] sn_block;
	logic [31:0] sn_len;
	logic [3:0]  tcount_inc;
	logic [15:0] prev_block;
	logic [15:0] next_block;

	assign pop       = head_valid && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign in_read    = (phase_q == PH_READ);
	assign match      = (head.src_addr == client_ip_q) && (head.src_port == client_port_q);
	assign prev_block = last_block_q - 16'd1;
	assign next_block = last_block_q + 16'd1;
	assign tcount_inc = (tcount_q < TIMEOUT_SAT) ? tcount_q + 4'd1 : tcount_q;

	// next DATA block: from the request on open, from the session otherwise
	assign sn_bytes = in_read ? bytes_left_q : head.file_bytes;
	assign sn_base  = in_read ? last_block_q : 16'd0;
	assign sn_block = sn_base + 16'd1;
	assign sn_len   = (sn_bytes < BLK32) ? sn_bytes : BLK32;

	always_comb begin
		phase_d       = phase_q;
		client_ip_d   = client_ip_q;
		client_port_d = client_port_q;
		last_block_d  = last_block_q;
		bytes_left_d  = bytes_left_q;
		last_len_d    = last_len_q;
		eof_d         = eof_q;
		tcount_d      = tcount_q;
		res_d         = '0;
		res_d.kind    = KIND_NONE;

		unique case (phase_q)
			PH_READ, PH_WRITE: begin
				if (head.tick) begin
					tcount_d = tcount_inc;
					if (tcount_inc >= max_timeouts) begin
						phase_d     = PH_IDLE;
						res_d.close = 1'b1;
					end else if (in_read) begin
						res_d.kind = KIND_DATA;
						res_d.blk  = last_block_q;
						res_d.len  = last_len_q;
						res_d.retx = 1'b1;
					end else begin
						res_d.kind = KIND_ACK;
						res_d.blk  = last_block_q;
						res_d.retx = 1'b1;
					end
				end else if (!match) begin
					// stray sender: answer it, leave the session alone
					res_d.kind      = KIND_ERR;
					res_d.err       = ERR_UNKNOWN_TID;
					res_d.to_sender = 1'b1;
				end else if (in_read) begin
					case (head.op)
						CLS_ACK: begin
							if (head.block_num == last_block_q) begin
								if (eof_q) begin
									phase_d     = PH_IDLE;
									res_d.close = 1'b1;
									res_d.ok    = 1'b1;
								end else begin
									last_block_d = sn_block;
									eof_d        = (sn_len != BLK32);
									bytes_left_d = sn_bytes - sn_len;
									last_len_d   = sn_len[9:0];
									res_d.kind   = KIND_DATA;
									res_d.blk    = sn_block;
									res_d.len    = sn_len[9:0];
								end
							end else if (head.block_num != prev_block) begin
								res_d.kind  = KIND_ERR;
								res_d.err   = ERR_ILLEGAL;
								phase_d     = PH_IDLE;
								res_d.close = 1'b1;
							end
						end
						CLS_ERROR: begin
							phase_d     = PH_IDLE;
							res_d.close = 1'b1;
						end
						default: begin
							res_d.kind  = KIND_ERR;
							res_d.err   = ERR_ILLEGAL;
							phase_d     = PH_IDLE;
							res_d.close = 1'b1;
						end
					endcase
				end else begin
					case (head.op)
						CLS_DATA: begin
							if (head.block_num == last_block_q) begin
								res_d.kind = KIND_ACK;
								res_d.blk  = last_block_q;
								res_d.retx = 1'b1;
							end else if (head.block_num == next_block) begin
								last_block_d = next_block;
								res_d.kind   = KIND_ACK;
								res_d.blk    = next_block;
								res_d.store  = 1'b1;
								// short block ends the upload
								if ({1'b0, head.payload_len} < BLK11) begin
									eof_d       = 1'b1;
									phase_d     = PH_IDLE;
									res_d.close = 1'b1;
									res_d.ok    = 1'b1;
								end
							end else begin
								res_d.kind    = KIND_ERR;
								res_d.err     = ERR_ILLEGAL;
								phase_d       = PH_IDLE;
								res_d.close   = 1'b1;
								res_d.discard = 1'b1;
							end
						end
						CLS_ERROR: begin
							phase_d       = PH_IDLE;
							res_d.close   = 1'b1;
							res_d.discard = 1'b1;
						end
						default: begin
							res_d.kind    = KIND_ERR;
							res_d.err     = ERR_ILLEGAL;
							phase_d       = PH_IDLE;
							res_d.close   = 1'b1;
							res_d.discard = 1'b1;
						end
					endcase
				end
			end
			default: begin
				// idle, and the unused phase code behaves as idle
				phase_d = PH_IDLE;
				if (!head.tick) begin
					if (head.op == CLS_RRQ || head.op == CLS_WRQ) begin
						if (!head.file_ok) begin
							res_d.kind      = KIND_ERR;
							res_d.err       = (head.op == CLS_RRQ) ? ERR_NOT_FOUND : ERR_EXISTS;
							res_d.to_sender = 1'b1;
						end else begin
							client_ip_d   = head.src_addr;
							client_port_d = head.src_port;
							tcount_d      = 4'd0;
							if (head.op == CLS_RRQ) begin
								phase_d      = PH_READ;
								last_block_d = sn_block;
								eof_d        = (sn_len != BLK32);
								bytes_left_d = sn_bytes - sn_len;
								last_len_d   = sn_len[9:0];
								res_d.kind   = KIND_DATA;
								res_d.blk    = sn_block;
								res_d.len    = sn_len[9:0];
							end else begin
								phase_d      = PH_WRITE;
								last_block_d = 16'd0;
								eof_d        = 1'b0;
								bytes_left_d = 32'd0;
								last_len_d   = 10'd0;
								res_d.kind   = KIND_ACK;
							end
						end
					end else begin
						res_d.kind      = KIND_ERR;
						res_d.err       = ERR_ILLEGAL;
						res_d.to_sender = 1'b1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			client_ip_q   <= '0;
			client_port_q <= '0;
			last_block_q  <= '0;
			bytes_left_q  <= '0;
			last_len_q    <= '0;
			eof_q         <= 1'b0;
			tcount_q      <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				phase_q       <= phase_d;
				client_ip_q   <= client_ip_d;
				client_port_q <= client_port_d;
				last_block_q  <= last_block_d;
				bytes_left_q  <= bytes_left_d;
				last_len_q    <= last_len_d;
				eof_q         <= eof_d;
				tcount_q      <= tcount_d;
				res_valid_q   <= 1'b1;
			end else if (res_ready) begin
				res_valid_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

endmodule

>>> design/tftp_server_transfer_fsm.sv
// Path: an accepted word is written into the queue; the back end then decides it from the
//   queue head and loads the result register.
// Throughput: one word per cycle sustained while res_ready stays high; the back end updates
//   session state as it loads the result, so back-to-back events never wait on it.
// Reset (arst_n low, asynchronous): session idle, all session state zero, queue empty,
//   no result pending, max_timeouts back to 5.
//
// Structure
//   front : decodes the opcode into a class and pushes a queue entry; it only stalls when
//           the queue is full.
//   queue : two-entry buffer between front and back, so a stalled result consumer does not
//           immediately back up the event producer.
//   back  : holds the session (client address/port, block number, bytes left, eof mark,
//           timeout count) and loads the result register, one event per cycle unless stalled.
//   config: max_timeouts is written through its own valid/ready channel, always ready.
module tftp_server_transfer_fsm #(
	parameter int unsigned BLOCK_BYTES = 512
) (
	input  logic        clk,
	input  logic        arst_n,

	// event channel
	input  logic        evt_valid,
	output logic        evt_ready,
	input  logic        req_type,
	input  logic [15:0] opcode,
	input  logic [15:0] block_num,
	input  logic [9:0]  payload_len,
	input  logic [31:0] src_addr,
	input  logic [15:0] src_port,
	input  logic        file_ok,
	input  logic [31:0] file_bytes,

	// result channel
	output logic        res_valid,
	input  logic        res_ready,
	output logic [1:0]  send_kind,
	output logic [15:0] send_block,
	output logic [9:0]  send_len,
	output logic        send_retx,
	output logic [2:0]  error_code,
	output logic        err_to_sender,
	output logic        store_payload,
	output logic        close_conn,
	output logic        discard_file,
	output logic        done_ok,

	// configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);
	import tftp_pkg::*;

	logic       q_full;
	logic       q_push;
	entry_t     q_entry;
	logic       q_pop;
	logic       head_valid;
	entry_t     head;
	result_t    res;
	logic [3:0] max_timeouts_q;

	// config register: always ready; the user must write it only while the block is quiet, the block does not enforce this
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_timeouts_q <= MAX_TIMEOUTS_RST;
		end else if (cfg_valid) begin
			max_timeouts_q <= cfg_data;
		end
	end

	tftp_front u_front (
		.evt_valid   (evt_valid),
		.evt_ready   (evt_ready),
		.req_type    (req_type),
		.opcode      (opcode),
		.block_num   (block_num),
		.payload_len (payload_len),
		.src_addr    (src_addr),
		.src_port    (src_port),
		.file_ok     (file_ok),
		.file_bytes  (file_bytes),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_entry     (q_entry)
	);

	tftp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	tftp_back #(
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (q_pop),
		.max_timeouts (max_timeouts_q),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	// unpack the result word onto its ports
	assign send_kind     = res.kind;
	assign send_block    = res.blk;
	assign send_len      = res.len;
	assign send_retx     = res.retx;
	assign error_code    = res.err;
	assign err_to_sender = res.to_sender;
	assign store_payload = res.store;
	assign close_conn    = res.close;
	assign discard_file  = res.discard;
	assign done_ok       = res.ok;

	// discarding the file only happens as part of ending the session
	a_discard_closes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && discard_file |-> close_conn)
		else $error("discard_file without close_conn");

	// a successful finish closes cleanly and keeps the file
	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_ok |-> close_conn && !discard_file && (error_code == ERR_NONE))
		else $error("done_ok with error or discard");

	// a stored payload is always acknowledged as a fresh block
	a_store_acks: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && store_payload |-> (send_kind == KIND_ACK) && !send_retx)
		else $error("store_payload without fresh ACK");

	// a session never ends while sending another DATA block
	a_close_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && close_conn |-> (send_kind != KIND_DATA))
		else $error("close_conn together with DATA");

endmodule

>>> sim/tftp_session_pkg.sv
package tftp_session_pkg;

	import tftp_pkg::*;

	localparam int unsigned BLOCK_BYTES = 512;

	// One received packet or timeout tick, as offered on the event channel
	typedef struct packed {
		logic        req_type;
		logic [15:0] opcode;
		logic [15:0] block_num;
		logic [9:0]  payload_len;
		logic [31:0] src_addr;
		logic [15:0] src_port;
		logic        file_ok;
		logic [31:0] file_bytes;
	} packet_t;

	// Tracks the server session and holds the reply words it must produce, oldest first
	class tftp_session_predictor;
		phase_t      phase;
		logic [31:0] client_ip;
		logic [15:0] client_port;
		logic [15:0] last_block;
		logic [31:0] bytes_left;
		logic [9:0]  last_len;
		logic        eof_seen;
		logic [3:0]  timeout_ticks;
		logic [3:0]  close_after;
		result_t     pending_replies[$];
		int unsigned mismatches;
		int unsigned packets_seen;
		int unsigned replies_checked;
		int unsigned transfers_done;

		function new();
			phase           = PH_IDLE;
			client_ip       = '0;
			client_port     = '0;
			last_block      = '0;
			bytes_left      = '0;
			last_len        = '0;
			eof_seen        = 1'b0;
			timeout_ticks   = '0;
			close_after     = MAX_TIMEOUTS_RST;
			mismatches      = 0;
			packets_seen    = 0;
			replies_checked = 0;
			transfers_done  = 0;
		endfunction

		function void end_session(inout result_t r, input logic discard, input logic ok);
			phase     = PH_IDLE;
			r.close   = 1'b1;
			r.discard = discard;
			r.ok      = ok;
			if (ok)
				transfers_done++;
		endfunction

		function void send_error(inout result_t r, input logic [2:0] code, input logic to_sender);
			r.kind      = KIND_ERR;
			r.err       = code;
			r.to_sender = to_sender;
		endfunction

		// Advance to the next block of the file being read; a short block marks the end
		function void send_next_block(inout result_t r);
			logic [31:0] n;
			n          = (bytes_left < BLOCK_BYTES) ? bytes_left : BLOCK_BYTES;
			last_block = last_block + 16'd1;
			eof_seen   = (n != BLOCK_BYTES);
			bytes_left = bytes_left - n;
			last_len   = n[9:0];
			r.kind     = KIND_DATA;
			r.blk      = last_block;
			r.len      = n[9:0];
		endfunction

		function void note_packet(packet_t p);
			result_t     r;
			logic [15:0] blk_prev;
			logic [15:0] blk_next;
			r        = '0;
			blk_prev = last_block - 16'd1;
			blk_next = last_block + 16'd1;
			packets_seen++;
			if (phase != PH_READ && phase != PH_WRITE) begin
				phase = PH_IDLE;
				if (p.req_type) begin
				end else if ((p.opcode == OPC_RRQ || p.opcode == OPC_WRQ) && !p.file_ok) begin
					send_error(r, (p.opcode == OPC_RRQ) ? ERR_NOT_FOUND : ERR_EXISTS, 1'b1);
				end else if (p.opcode == OPC_RRQ || p.opcode == OPC_WRQ) begin
					client_ip     = p.src_addr;
					client_port   = p.src_port;
					last_block    = '0;
					eof_seen      = 1'b0;
					timeout_ticks = '0;
					last_len      = '0;
					if (p.opcode == OPC_RRQ) begin
						phase      = PH_READ;
						bytes_left = p.file_bytes;
						send_next_block(r);
					end else begin
						phase      = PH_WRITE;
						bytes_left = '0;
						r.kind     = KIND_ACK;
					end
				end else begin
					send_error(r, ERR_ILLEGAL, 1'b1);
				end
			end else if (p.req_type) begin
				if (timeout_ticks != TIMEOUT_SAT)
					timeout_ticks++;
				if (timeout_ticks >= close_after) begin
					end_session(r, 1'b0, 1'b0);
				end else begin
					r.kind = (phase == PH_READ) ? KIND_DATA : KIND_ACK;
					r.blk  = last_block;
					r.len  = (phase == PH_READ) ? last_len : 10'd0;
					r.retx = 1'b1;
				end
			end else if (p.src_addr != client_ip || p.src_port != client_port) begin
				send_error(r, ERR_UNKNOWN_TID, 1'b1);
			end else if (phase == PH_READ) begin
				if (p.opcode == OPC_ACK) begin
					if (p.block_num == last_block) begin
						if (eof_seen)
							end_session(r, 1'b0, 1'b1);
						else
							send_next_block(r);
					end else if (p.block_num != blk_prev) begin
						send_error(r, ERR_ILLEGAL, 1'b0);
						end_session(r, 1'b0, 1'b0);
					end
				end else if (p.opcode == OPC_ERROR) begin
					end_session(r, 1'b0, 1'b0);
				end else begin
					send_error(r, ERR_ILLEGAL, 1'b0);
					end_session(r, 1'b0, 1'b0);
				end
			end else begin
				if (p.opcode == OPC_DATA) begin
					if (p.block_num == last_block) begin
						r.kind = KIND_ACK;
						r.blk  = last_block;
						r.retx = 1'b1;
					end else if (p.block_num == blk_next) begin
						last_block = blk_next;
						r.kind     = KIND_ACK;
						r.blk      = last_block;
						r.store    = 1'b1;
						if (p.payload_len < BLOCK_BYTES) begin
							eof_seen = 1'b1;
							end_session(r, 1'b0, 1'b1);
						end
					end else begin
						send_error(r, ERR_ILLEGAL, 1'b0);
						end_session(r, 1'b1, 1'b0);
					end
				end else if (p.opcode == OPC_ERROR) begin
					end_session(r, 1'b1, 1'b0);
				end else begin
					send_error(r, ERR_ILLEGAL, 1'b0);
					end_session(r, 1'b1, 1'b0);
				end
			end
			pending_replies.push_back(r);
		endfunction

		// Print at most the first hundred, but count them all
		task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
			mismatches++;
			if (mismatches <= 100)
				$display("mismatch on reply %0d, %s: got 0x%0h, expected 0x%0h",
					replies_checked, what, got, want);
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				flag_mismatch(name, got, want);
		endtask

		task check_reply(result_t got);
			result_t want;
			if (pending_replies.size() == 0) begin
				flag_mismatch("reply word with nothing pending", 32'(got), '0);
				return;
			end
			want = pending_replies.pop_front();
			replies_checked++;
			compare_field("send_kind", 32'(got.kind), 32'(want.kind));
			compare_field("send_block", 32'(got.blk), 32'(want.blk));
			compare_field("send_len", 32'(got.len), 32'(want.len));
			compare_field("send_retx", 32'(got.retx), 32'(want.retx));
			compare_field("error_code", 32'(got.err), 32'(want.err));
			compare_field("err_to_sender", 32'(got.to_sender), 32'(want.to_sender));
			compare_field("store_payload", 32'(got.store), 32'(want.store));
			compare_field("close_conn", 32'(got.close), 32'(want.close));
			compare_field("discard_file", 32'(got.discard), 32'(want.discard));
			compare_field("done_ok", 32'(got.ok), 32'(want.ok));
		endtask
	endclass

endpackage

>>> sim/testbench.sv
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import tftp_pkg::*;
	import tftp_session_pkg::*;

	// Two fixed clients for the hand-written sequences
	localparam logic [31:0] CLI_A_ADDR = 32'hC0A8_0001;
	localparam logic [15:0] CLI_A_PORT = 16'd1069;
	localparam logic [31:0] CLI_B_ADDR = 32'hFFFF_FFFF;
	localparam logic [15:0] CLI_B_PORT = 16'hFFFF;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        evt_valid = 1'b0;
	logic        evt_ready;
	packet_t     evt_word  = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [1:0]  send_kind;
	logic [15:0] send_block;
	logic [9:0]  send_len;
	logic        send_retx;
	logic [2:0]  error_code;
	logic        err_to_sender;
	logic        store_payload;
	logic        close_conn;
	logic        discard_file;
	logic        done_ok;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_data  = '0;

	tftp_session_predictor model;
	int                    idle_pct    = 0;  // chance in percent that a word starts an idle burst
	int                    stall_left  = 0;
	int unsigned           limit_count = 0;

	always #5 clk = ~clk;

	tftp_server_transfer_fsm #(
		.BLOCK_BYTES(BLOCK_BYTES)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.evt_valid    (evt_valid),
		.evt_ready    (evt_ready),
		.req_type     (evt_word.req_type),
		.opcode       (evt_word.opcode),
		.block_num    (evt_word.block_num),
		.payload_len  (evt_word.payload_len),
		.src_addr     (evt_word.src_addr),
		.src_port     (evt_word.src_port),
		.file_ok      (evt_word.file_ok),
		.file_bytes   (evt_word.file_bytes),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.send_kind    (send_kind),
		.send_block   (send_block),
		.send_len     (send_len),
		.send_retx    (send_retx),
		.error_code   (error_code),
		.err_to_sender(err_to_sender),
		.store_payload(store_payload),
		.close_conn   (close_conn),
		.discard_file (discard_file),
		.done_ok      (done_ok),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// Check every reply word at the edge where it is taken. Values read here are the
	// ones that held just before the edge, so the check does not race the block.
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			model.check_reply(result_t'({send_kind, send_block, send_len, send_retx, error_code,
				err_to_sender, store_payload, close_conn, discard_file, done_ok}));
	end

	// Stall the reply side in bursts of random length; one assignment per edge
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			res_ready <= 1'b0;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			stall_left = $urandom_range(0, 15);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	// Offer one word and hold it until taken, then let the model see it. Valid is only
	// dropped when an idle burst begins, never in the step that raises it again.
	task automatic push_packet(input packet_t p);
		if ($urandom_range(0, 99) < idle_pct) begin
			evt_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		evt_valid <= 1'b1;
		evt_word  <= p;
		do @(posedge clk); while (!evt_ready);
		model.note_packet(p);
	endtask

	// Every field but req_type random, so bits the block ignores still toggle
	function automatic packet_t random_packet();
		packet_t p;
		p.req_type    = 1'b0;
		p.opcode      = 16'($urandom());
		p.block_num   = 16'($urandom());
		p.payload_len = 10'($urandom());
		p.src_addr    = $urandom();
		p.src_port    = 16'($urandom());
		p.file_ok     = 1'($urandom());
		p.file_bytes  = $urandom();
		return p;
	endfunction

	task automatic send_pkt(input logic [15:0] op, input logic [15:0] blk, input logic [9:0] plen,
		input logic [31:0] addr, input logic [15:0] port, input logic ok, input logic [31:0] size);
		packet_t p;
		p = '{1'b0, op, blk, plen, addr, port, ok, size};
		push_packet(p);
	endtask

	task automatic send_tick();
		packet_t p;
		p          = random_packet();
		p.req_type = 1'b1;
		push_packet(p);
	endtask

	// Drop valid and hold until every reply has come back; each word makes exactly one
	// reply, so an empty list means the block is idle.
	task automatic wait_idle();
		evt_valid <= 1'b0;
		while (model.pending_replies.size() != 0) @(posedge clk);
	endtask

	task automatic write_limit(input logic [3:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		model.close_after = v;
		limit_count++;
	endtask

	// One random word, mostly the next one a well-behaved peer would send, so sessions run
	// long; the rest are ticks, duplicates, strangers, peer errors and protocol violations.
	task automatic random_step();
		packet_t p;
		int      roll;
		p          = random_packet();
		p.src_addr = model.client_ip;
		p.src_port = model.client_port;
		roll       = $urandom_range(0, 99);
		if (model.phase == PH_IDLE) begin
			p.src_addr = $urandom();
			p.src_port = 16'($urandom());
			if (roll < 45) begin
				p.opcode  = OPC_RRQ;
				p.file_ok = 1'b1;
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: p.file_bytes = $urandom_range(0, 3000);
					6, 7:             p.file_bytes = $urandom_range(0, 6) * BLOCK_BYTES;
					default:          p.file_bytes = $urandom();
				endcase
			end else if (roll < 80) begin
				p.opcode  = OPC_WRQ;
				p.file_ok = 1'b1;
			end else if (roll < 90) begin
				p.opcode  = $urandom_range(0, 1) ? OPC_RRQ : OPC_WRQ;
				p.file_ok = 1'b0;
			end else if (roll < 95) begin
				p.req_type = 1'b1;
			end else if ($urandom_range(0, 1)) begin
				p.opcode = 16'($urandom_range(OPC_DATA, OPC_ERROR));
			end
		end else if (roll < 70) begin
			if (model.phase == PH_READ) begin
				p.opcode    = OPC_ACK;
				p.block_num = model.last_block;
			end else begin
				p.opcode    = OPC_DATA;
				p.block_num = model.last_block + 16'd1;
				case ($urandom_range(0, 9))
					0:       p.payload_len = 10'($urandom_range(0, BLOCK_BYTES - 1));
					1:       p.payload_len = 10'($urandom_range(BLOCK_BYTES + 1, 1023));
					default: p.payload_len = 10'(BLOCK_BYTES);
				endcase
			end
		end else if (roll < 78) begin
			p.req_type = 1'b1;
		end else if (roll < 83) begin
			if (model.phase == PH_READ) begin
				p.opcode    = OPC_ACK;
				p.block_num = model.last_block - 16'd1;
			end else begin
				p.opcode    = OPC_DATA;
				p.block_num = model.last_block;
			end
		end else if (roll < 88) begin
			if ($urandom_range(0, 1))
				p.src_addr = p.src_addr ^ (32'd1 << $urandom_range(0, 31));
			else
				p.src_port = p.src_port ^ (16'd1 << $urandom_range(0, 15));
		end else if (roll < 92) begin
			p.opcode = OPC_ERROR;
		end else if (roll < 96) begin
			case ($urandom_range(0, 3))
				0:       p.opcode = OPC_RRQ;
				1:       p.opcode = OPC_WRQ;
				2:       p.opcode = (model.phase == PH_READ) ? OPC_DATA : OPC_ACK;
				default: ;
			endcase
		end else begin
			p.opcode = (model.phase == PH_READ) ? OPC_ACK : OPC_DATA;
		end
		push_packet(p);
	endtask

	initial begin
		int lim;
		model = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle: a tick does nothing, strays and refusals get errors to the sender
		send_tick();
		send_pkt(OPC_DATA, 16'd1, 10'd0, CLI_A_ADDR, CLI_A_PORT, 1'b1, 32'd0);
		send_pkt(16'hFFFF, 16'hFFFF, 10'h3FF, CLI_A_ADDR, CLI_A_PORT, 1'b1, 32'd0);
		send_pkt(16'h0000, 16'd0, 10'd0, CLI_A_ADDR, CLI_A_PORT, 1'b1, 32'd0);
		send_pkt(OPC_RRQ, 16'd0, 10'd0, CLI_A_ADDR, CLI_A_PORT, 1'b0, 32'd100);
		send_pkt(OPC_WRQ, 16'd0, 10'd0, CLI_A_ADDR, CLI_A_PORT, 1'b0, 32'd0);

		// Read of two full blocks and a short one: stranger, duplicate ACK, retransmit
		send_pkt(OPC_RRQ, 16'd0, 10'd0, CLI_A_ADDR, CLI_A_PORT, 1'b1, 32'd1030);
		send_pkt(OPC_ACK, 16'd1, 10'd0, CLI_A_ADDR, CLI_A_PORT + 16'd1, 1'b1, 32'd0);
		send_pkt(OPC_ACK, 16'd1, 10'd0, CLI_A_ADDR, CLI_A_PORT, 1'b1, 32'd0);
		send_pkt(OPC_ACK, 16'd1, 10'd0, CLI_A_ADDR, CLI_A_PORT, 1'b1, 32'd0);
		send_tick();
		send_pkt(OPC_ACK, 16'd2, 10'd0, CLI_A_ADDR, CLI_A_PORT, 1'b1, 32'd0);
		send_pkt(OPC_ACK, 16'd3, 10'd0, CLI_A_ADDR, CLI_A_PORT, 1'b1, 32'd0);

		// Write: duplicate DATA, oversize payload, out-of-order block
		send_pkt(OPC_WRQ, 16'd0, 10'd0, CLI_B_ADDR, CLI_B_PORT, 1'b1, 32'd0);
		send_pkt(OPC_DATA, 16'd0, 10'd512, CLI_B_ADDR, CLI_B_PORT, 1'b1, 32'd0);
		send_pkt(OPC_DATA, 16'd1, 10'h3FF, CLI_B_ADDR, CLI_B_PORT, 1'b1, 32'd0);
		send_pkt(OPC_DATA, 16'd5, 10'd512, CLI_B_ADDR, CLI_B_PORT, 1'b1, 32'd0);
		send_pkt(OPC_WRQ, 16'd0, 10'd0, CLI_B_ADDR, CLI_B_PORT, 1'b1, 32'd0);
		send_pkt(OPC_ERROR, 16'd0, 10'd0, CLI_B_ADDR, CLI_B_PORT, 1'b1, 32'd0);

		// Empty file, bad ACK number, request inside a session, one-block empty write
		send_pkt(OPC_RRQ, 16'd0, 10'd0, 32'd0, 16'd0, 1'b1, 32'd0);
		send_pkt(OPC_ACK, 16'd7, 10'd0, 32'd0, 16'd0, 1'b1, 32'd0);
		send_pkt(OPC_RRQ, 16'd0, 10'd0, CLI_A_ADDR, CLI_A_PORT, 1'b1, 32'd512);
		send_pkt(OPC_WRQ, 16'd0, 10'd0, CLI_A_ADDR, CLI_A_PORT, 1'b1, 32'd0);
		send_pkt(OPC_WRQ, 16'd0, 10'd0, CLI_A_ADDR, CLI_A_PORT, 1'b1, 32'd0);
		send_pkt(OPC_DATA, 16'd1, 10'd0, CLI_A_ADDR, CLI_A_PORT, 1'b1, 32'd0);

		// Timeout limit at both ends: one tick closes, then fourteen resends before closing
		wait_idle();
		write_limit(4'd1);
		send_pkt(OPC_RRQ, 16'd0, 10'd0, CLI_A_ADDR, CLI_A_PORT, 1'b1, 32'd2000);
		send_tick();
		wait_idle();
		write_limit(4'd15);
		send_pkt(OPC_WRQ, 16'd0, 10'd0, CLI_B_ADDR, CLI_B_PORT, 1'b1, 32'd0);
		repeat (15) send_tick();

		// Random sessions in five stretches, each with its own limit and idle rate;
		// the last stretch runs with no idling at all
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0:       begin lim = 3;                     idle_pct = 20; end
				1:       begin lim = 15;                    idle_pct = 0;  end
				2:       begin lim = $urandom_range(1, 15); idle_pct = 40; end
				3:       begin lim = 1;                     idle_pct = 10; end
				default: begin lim = 5;                     idle_pct = 0;  end
			endcase
			wait_idle();
			write_limit(lim[3:0]);
			repeat (140) random_step();
		end

		// Drain, then give the queue and result register time to show any stray word
		idle_pct = 0;
		wait_idle();
		repeat (8) @(posedge clk);

		$display("Covered %0d packets and ticks, %0d reply words, %0d completed transfers.",
			model.packets_seen, model.replies_checked, model.transfers_done);
		$display("Timeout limit written %0d times across directed and random sessions.",
			limit_count);
		if (model.mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", model.mismatches);
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog: the whole run needs well under a third of this
	initial begin
		#5_000_000;
		$display("timeout with %0d replies still pending", model.pending_replies.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
